@@ design/xwtr_pkg.sv @@
// Package for the xorshift32 generator with Weyl sequence and output tempering.
// Holds the command and mode codes, the job and state types and the mixing functions.
// It depends on nothing else.
package xwtr_pkg;

   localparam int unsigned XWTR_QUEUE_DEPTH = 2;

   localparam logic [31:0] WEYL_STEP   = 32'h9E37_79B9;
   localparam logic [31:0] MURMUR_MUL1 = 32'h85EB_CA6B;
   localparam logic [31:0] MURMUR_MUL2 = 32'hC2B2_AE35;
   localparam logic [31:0] STATE_RESET = 32'h0000_0001;

   localparam logic       CMD_DRAW    = 1'b0;
   localparam logic       CMD_SEED    = 1'b1;

   localparam logic [1:0] MODE_PLAIN  = 2'd0;
   localparam logic [1:0] MODE_MURMUR = 2'd1;
   localparam logic [1:0] MODE_SHIFT  = 2'd2;

   typedef enum logic [1:0] {
      JOB_PLAIN,
      JOB_MURMUR,
      JOB_SHIFT
   } xwtr_job_kind_type;

   typedef struct packed {
      xwtr_job_kind_type kind;
      logic [31:0]       value;
   } xwtr_job_type;

   typedef struct packed {
      logic         valid;
      xwtr_job_type job;
   } xwtr_push_type;

   typedef struct packed {
      logic         valid;
      xwtr_job_type job;
   } xwtr_head_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_MUL2,
      BACK_FINAL,
      BACK_DONE
   } xwtr_back_state_type;

   function automatic logic [31:0] xorshift_next(input logic [31:0] v);
      logic [31:0] a;
      logic [31:0] b;
      a = v ^ (v << 13);
      b = a ^ (a >> 17);
      return b ^ (b << 5);
   endfunction

   function automatic logic [31:0] shift_mix(input logic [31:0] v);
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [31:0] d;
      a = v ^ (v >> 16);
      b = a ^ (a << 10);
      c = b ^ (b >> 4);
      d = c ^ (c << 5);
      return d ^ (d >> 15);
   endfunction

endpackage

@@ design/xwtr_if.sv @@
// Handshake interfaces for the request, response and register write channels.
// Each carries valid, ready and the payload; it depends on nothing else.
interface xwtr_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [31:0] seed_value;

   modport source (output valid, output cmd, output seed_value, input ready);
   modport sink (input valid, input cmd, input seed_value, output ready);
endinterface

interface xwtr_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] random_value;

   modport source (output valid, output random_value, input ready);
   modport sink (input valid, input random_value, output ready);
endinterface

interface xwtr_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] mix_mode;

   modport source (output valid, output mix_mode, input ready);
   modport sink (input valid, input mix_mode, output ready);
endinterface

@@ design/xwtr_front.sv @@
// Front end: takes request items and mode writes, advances the xorshift state and
// the Weyl counter, and pushes a job for each draw. Depends on xwtr_pkg and xwtr_if.
module xwtr_front
   import xwtr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   xwtr_req_if.sink      req_chan,
   xwtr_csr_if.sink      csr_chan,
   input  logic          queue_full,
   output xwtr_push_type push
);

   logic [31:0] shift_state_ff;
   logic [31:0] shift_state_in;
   logic [31:0] weyl_ff;
   logic [31:0] weyl_in;
   logic [1:0]  mode_ff;
   logic [1:0]  mode_in;
   logic        accept;
   logic [31:0] next_state;
   logic [31:0] next_weyl;

   assign req_chan.ready = !queue_full;
   assign csr_chan.ready = 1'b1;
   assign accept         = req_chan.valid && !queue_full;
   assign next_state     = xorshift_next(shift_state_ff);
   assign next_weyl      = weyl_ff + WEYL_STEP;

   always_comb begin
      mode_in        = csr_chan.valid ? csr_chan.mix_mode : mode_ff;
      shift_state_in = shift_state_ff;
      weyl_in        = weyl_ff;
      push.valid     = 1'b0;
      push.job.kind  = JOB_PLAIN;
      push.job.value = next_state;
      if (accept) begin
         if (req_chan.cmd == CMD_SEED) begin
            shift_state_in = req_chan.seed_value;
            weyl_in        = '0;
         end else begin
            shift_state_in = next_state;
            push.valid     = 1'b1;
            case (mode_ff)
               MODE_MURMUR: begin
                  weyl_in        = next_weyl;
                  push.job.kind  = JOB_MURMUR;
                  push.job.value = next_state + next_weyl;
               end
               MODE_SHIFT: begin
                  weyl_in        = next_weyl;
                  push.job.kind  = JOB_SHIFT;
                  push.job.value = next_state + next_weyl;
               end
               default: begin
                  push.job.kind  = JOB_PLAIN;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_state_ff <= STATE_RESET;
         weyl_ff        <= '0;
         mode_ff        <= MODE_PLAIN;
      end else begin
         shift_state_ff <= shift_state_in;
         weyl_ff        <= weyl_in;
         mode_ff        <= mode_in;
      end
   end

endmodule

@@ design/xwtr_queue.sv @@
// Short job queue between the front end and the back end.
// Depends on xwtr_pkg for the job and handshake structs.
module xwtr_queue
   import xwtr_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = XWTR_QUEUE_DEPTH
) (
   input  logic          clock,
   input  logic          reset,
   input  xwtr_push_type push,
   input  logic          pop,
   output logic          full,
   output xwtr_head_type head
);

   localparam int unsigned PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned COUNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0]   PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(QUEUE_DEPTH);

   xwtr_job_type       entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic               do_push;
   logic               do_pop;

   assign full       = (count_ff == COUNT_MAX);
   assign head.valid = (count_ff != '0);
   assign head.job   = entries_ff[rd_ptr_ff];
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push.job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ design/xwtr_back.sv @@
// Back end: takes jobs from the queue, applies the selected output mixing with one
// shared multiplier and holds the result for the response channel. Depends on xwtr_pkg.
module xwtr_back
   import xwtr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  xwtr_head_type head,
   output logic          pop,
   xwtr_rsp_if.source    rsp_chan
);

   xwtr_back_state_type state_ff;
   xwtr_back_state_type state_in;
   logic [31:0]         acc_ff;
   logic [31:0]         acc_in;
   logic [31:0]         result_ff;
   logic [31:0]         result_in;
   logic [31:0]         mul_a;
   logic [31:0]         mul_b;
   logic [63:0]         product;

   assign product = mul_a * mul_b;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BACK_IDLE: begin
            if (head.valid) begin
               state_in = (head.job.kind == JOB_MURMUR) ? BACK_MUL2 : BACK_DONE;
            end
         end
         BACK_MUL2: begin
            state_in = BACK_FINAL;
         end
         BACK_FINAL: begin
            state_in = BACK_DONE;
         end
         BACK_DONE: begin
            if (rsp_chan.ready) begin
               state_in = BACK_IDLE;
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   always_comb begin
      pop            = 1'b0;
      mul_a          = head.job.value ^ (head.job.value >> 16);
      mul_b          = MURMUR_MUL1;
      acc_in         = acc_ff;
      result_in      = result_ff;
      rsp_chan.valid = 1'b0;
      case (state_ff)
         BACK_IDLE: begin
            pop = head.valid;
            case (head.job.kind)
               JOB_MURMUR: acc_in    = product[31:0];
               JOB_SHIFT:  result_in = shift_mix(head.job.value);
               default:    result_in = head.job.value;
            endcase
         end
         BACK_MUL2: begin
            mul_a  = acc_ff ^ (acc_ff >> 13);
            mul_b  = MURMUR_MUL2;
            acc_in = product[31:0];
         end
         BACK_FINAL: begin
            result_in = acc_ff ^ (acc_ff >> 16);
         end
         BACK_DONE: begin
            rsp_chan.valid = 1'b1;
         end
         default: begin
            pop = 1'b0;
         end
      endcase
   end

   assign rsp_chan.random_value = result_ff;

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      result_ff <= result_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BACK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ design/xorshift32_weyl_tempered_rng_top.sv @@
// Seed items give no result; each draw item gives one result.
// Throughput: the front end takes one item a cycle while the queue has room; the back end
// sequencer with its one shared multiplier works on one draw at a time, going from idle
// to done (through mul2 and final in multiply mode) and holding done until the response
// is taken. Reset (synchronous) sets the state to one, the Weyl counter and mode to
// zero and empties the queue.
module xorshift32_weyl_tempered_rng_top
   import xwtr_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = XWTR_QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   xwtr_req_if.sink   req_chan,
   xwtr_rsp_if.source rsp_chan,
   xwtr_csr_if.sink   csr_chan
);

   xwtr_push_type push;
   xwtr_head_type head;
   logic          queue_full;
   logic          pop;

   xwtr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .csr_chan   (csr_chan),
      .queue_full (queue_full),
      .push       (push)
   );

   xwtr_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (queue_full),
      .head  (head)
   );

   xwtr_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the xorshift32 generator with Weyl sequence and tempering.
// Drives seed and draw items through the request channel, checks every response against
// its own predictor and steps the mode register through all codes; needs the RTL only.
module tb_top;
   import xwtr_pkg::*;

   localparam logic [1:0] MODE_SPARE   = 2'd3;
   localparam int         DRAIN_CYCLES = 12;
   localparam int         LONG_HOLD    = 400;
   localparam int         IDLE_LIMIT   = 3000;
   localparam int         PHASE_ITEMS  = 100;

   typedef struct packed {
      logic        cmd;
      logic [31:0] seed_value;
   } rng_request_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_COIN,
      STALL_SPARSE,
      STALL_PERIODIC
   } stall_style_type;

   logic clock;
   logic reset;

   xwtr_req_if req_chan ();
   xwtr_rsp_if rsp_chan ();
   xwtr_csr_if csr_chan ();

   xorshift32_weyl_tempered_rng_top i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   rng_request_type pending_items[$];
   logic [31:0]     expected_values[$];

   logic [31:0]  model_state;
   logic [31:0]  model_weyl;
   logic [1:0]   model_mode;

   int           queued_count    = 0;
   int           accepted_count  = 0;
   int           draws_queued    = 0;
   int           seeds_queued    = 0;
   int           results_checked = 0;
   int           mode_writes     = 0;
   int           error_count     = 0;
   int           idle_cycles     = 0;
   logic         req_taken       = 1'b0;

   int              burst_left      = 0;
   int              gap_left        = 0;
   int              hold_request    = 0;
   int              hold_served     = 0;
   int              hold_left       = 0;
   int              style_left      = 0;
   int              cycle_count     = 0;
   stall_style_type stall_style     = STALL_NONE;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [31:0] advance_state(input logic [31:0] s);
      logic [31:0] t;
      t = s ^ {s[18:0], 13'b0};
      t = t ^ {17'b0, t[31:17]};
      t = t ^ {t[26:0], 5'b0};
      return t;
   endfunction

   function automatic logic [31:0] murmur_finalise(input logic [31:0] v);
      logic [31:0] t;
      t = v ^ {16'b0, v[31:16]};
      t = t * MURMUR_MUL1;
      t = t ^ {13'b0, t[31:13]};
      t = t * MURMUR_MUL2;
      t = t ^ {16'b0, t[31:16]};
      return t;
   endfunction

   function automatic logic [31:0] shift_temper(input logic [31:0] v);
      logic [31:0] t;
      t = v ^ {16'b0, v[31:16]};
      t = t ^ {t[21:0], 10'b0};
      t = t ^ {4'b0, t[31:4]};
      t = t ^ {t[26:0], 5'b0};
      t = t ^ {15'b0, t[31:15]};
      return t;
   endfunction

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 7))
         0: begin
            return 32'h0000_0000;
         end
         1: begin
            return 32'hFFFF_FFFF;
         end
         2: begin
            return 32'h1 << $urandom_range(0, 31);
         end
         default: begin
            return $urandom();
         end
      endcase
   endfunction

   task automatic queue_item(input logic cmd, input logic [31:0] seed_value);
      rng_request_type item;
      item.cmd        = cmd;
      item.seed_value = seed_value;
      pending_items.push_back(item);
      queued_count++;
      if (cmd == CMD_SEED) begin
         seeds_queued++;
      end else begin
         draws_queued++;
      end
   endtask

   task automatic wait_for_drain();
      while (accepted_count != queued_count || expected_values.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input logic [1:0] mode);
      @(negedge clock);
      csr_chan.valid    <= 1'b1;
      csr_chan.mix_mode <= mode;
      do begin
         @(posedge clock);
      end while (!(csr_chan.valid && csr_chan.ready));
      @(negedge clock);
      csr_chan.valid    <= 1'b0;
   endtask

   // Request driver: offers queued items in bursts and holds each until it is taken.
   always @(negedge clock) begin : req_driver
      rng_request_type item;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (req_chan.valid && !req_taken) begin
      end else if (gap_left > 0) begin
         gap_left--;
         req_chan.valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
         item = pending_items.pop_front();
         req_chan.valid      <= 1'b1;
         req_chan.cmd        <= item.cmd;
         req_chan.seed_value <= item.seed_value;
         if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
         end else begin
            burst_left--;
         end
      end else begin
         req_chan.valid <= 1'b0;
      end
   end

   // Response back-pressure, with a long hold-off whenever one is requested.
   always @(negedge clock) begin : rsp_stall
      cycle_count++;
      if (hold_request != hold_served) begin
         hold_served = hold_request;
         hold_left   = LONG_HOLD;
      end
      if (style_left == 0) begin
         stall_style = stall_style_type'($urandom_range(0, 3));
         style_left  = $urandom_range(20, 80);
      end else begin
         style_left--;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         case (stall_style)
            STALL_NONE: begin
               rsp_chan.ready <= 1'b1;
            end
            STALL_COIN: begin
               rsp_chan.ready <= 1'($urandom_range(0, 1));
            end
            STALL_SPARSE: begin
               rsp_chan.ready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
               rsp_chan.ready <= (cycle_count % 3 != 0);
            end
         endcase
      end
   end

   // Monitor and predictor: works out each draw at acceptance and checks responses in order.
   always @(posedge clock) begin : rng_monitor
      logic [31:0] value;
      logic [31:0] wanted;
      req_taken = 1'b0;
      if (reset) begin
         model_state = STATE_RESET;
         model_weyl  = 32'h0000_0000;
         model_mode  = MODE_PLAIN;
      end else begin
         if (csr_chan.valid && csr_chan.ready) begin
            model_mode = csr_chan.mix_mode;
            mode_writes++;
         end
         if (req_chan.valid && req_chan.ready) begin
            req_taken = 1'b1;
            accepted_count++;
            if (req_chan.cmd == CMD_SEED) begin
               model_state = req_chan.seed_value;
               model_weyl  = 32'h0000_0000;
            end else begin
               model_state = advance_state(model_state);
               value       = model_state;
               if (model_mode == MODE_MURMUR || model_mode == MODE_SHIFT) begin
                  model_weyl = model_weyl + WEYL_STEP;
                  value      = value + model_weyl;
                  value      = (model_mode == MODE_MURMUR) ? murmur_finalise(value)
                                                           : shift_temper(value);
               end
               expected_values.push_back(value);
            end
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_values.size() == 0) begin
               $error("random_value: no item expected, actual %h", rsp_chan.random_value);
               error_count++;
            end else begin
               wanted = expected_values.pop_front();
               results_checked++;
               if (rsp_chan.random_value !== wanted) begin
                  $error("random_value: expected %h, actual %h", wanted, rsp_chan.random_value);
                  error_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (!reset) begin
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
             || (csr_chan.valid && csr_chan.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   initial begin : stimulus
      logic [1:0] phase_modes[8];
      logic [1:0] mode;
      req_chan.valid      = 1'b0;
      req_chan.cmd        = CMD_DRAW;
      req_chan.seed_value = 32'h0000_0000;
      rsp_chan.ready      = 1'b0;
      csr_chan.valid      = 1'b0;
      csr_chan.mix_mode   = MODE_PLAIN;
      reset               = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset state in plain mode, then a stuck zero seed and both seed extremes.
      queue_item(CMD_DRAW, 32'hFFFF_FFFF);
      queue_item(CMD_DRAW, 32'h0000_0000);
      queue_item(CMD_SEED, 32'h0000_0000);
      queue_item(CMD_DRAW, 32'hFFFF_FFFF);
      queue_item(CMD_DRAW, 32'h0000_0000);
      queue_item(CMD_SEED, 32'hFFFF_FFFF);
      queue_item(CMD_DRAW, 32'h0000_0000);
      queue_item(CMD_SEED, 32'h8000_0000);
      queue_item(CMD_DRAW, 32'hFFFF_FFFF);
      wait_for_drain();

      // A zero seed in the tempered modes still varies through the Weyl counter.
      write_mode(MODE_MURMUR);
      queue_item(CMD_SEED, 32'h0000_0000);
      queue_item(CMD_DRAW, 32'h0000_0000);
      queue_item(CMD_DRAW, 32'hFFFF_FFFF);
      queue_item(CMD_SEED, 32'hFFFF_FFFF);
      queue_item(CMD_DRAW, 32'h0000_0000);
      wait_for_drain();

      write_mode(MODE_SHIFT);
      queue_item(CMD_SEED, 32'h0000_0000);
      queue_item(CMD_DRAW, 32'hFFFF_FFFF);
      queue_item(CMD_DRAW, 32'h0000_0000);
      queue_item(CMD_SEED, 32'h0000_0001);
      wait_for_drain();

      // The spare mode code acts as plain mode and leaves the Weyl counter alone.
      write_mode(MODE_SPARE);
      queue_item(CMD_DRAW, 32'h0000_0000);
      queue_item(CMD_DRAW, 32'hFFFF_FFFF);
      wait_for_drain();

      write_mode(MODE_PLAIN);
      queue_item(CMD_DRAW, 32'h0000_0000);
      queue_item(CMD_SEED, 32'h0000_0000);
      queue_item(CMD_DRAW, 32'hFFFF_FFFF);
      wait_for_drain();

      phase_modes = '{MODE_MURMUR, MODE_SHIFT, MODE_PLAIN, MODE_SPARE,
                      MODE_SHIFT, MODE_MURMUR, MODE_PLAIN, MODE_SHIFT};
      for (int phase = 0; phase < 8; phase++) begin
         mode = (phase >= 6) ? 2'($urandom_range(0, 3)) : phase_modes[phase];
         write_mode(mode);
         if (phase == 1) begin
            hold_request++;
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 99) < 15) begin
               queue_item(CMD_SEED, pick_word());
            end else begin
               queue_item(CMD_DRAW, $urandom());
            end
         end
         wait_for_drain();
      end

      if (expected_values.size() != 0) begin
         $error("random_value: %0d expected items never arrived", expected_values.size());
         error_count++;
      end
      $display("Covered %0d items (%0d draws, %0d seeds) over %0d mode writes.",
               accepted_count, draws_queued, seeds_queued, mode_writes);
      $display("Checked %0d responses, %0d errors.", results_checked, error_count);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
